[rtl/fcct_pkg.sv]
// Shared constants and codes for the FAT cluster chain table block.
`default_nettype none

package fcct_pkg;

    // Default size of the table store in bytes; a multiple of four.
    localparam int unsigned TABLE_BYTES_DEF = 131072;

    // Byte lanes of the table store.
    localparam int unsigned LANES = 4;

    // Width used for byte offsets and end offsets of an entry.
    localparam int unsigned OFF_W = 31;

    // Table kinds held in the fat_kind register.
    localparam logic [1:0] KIND_FAT12 = 2'd0;
    localparam logic [1:0] KIND_FAT16 = 2'd1;
    localparam logic [1:0] KIND_FAT32 = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FAT_KIND   = 2'd0;
    localparam logic [1:0] CFG_SPC        = 2'd1;
    localparam logic [1:0] CFG_FIRST_DATA = 2'd2;

    // Request codes.
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Entry masks.
    localparam logic [15:0] MASK_FAT12    = 16'h0FFF;
    localparam logic [31:0] MASK_FAT32    = 32'h0FFF_FFFF;
    localparam logic [31:0] KEEP_FAT32    = 32'hF000_0000;
    localparam logic [15:0] KEEP_ODD12    = 16'h000F;
    localparam logic [15:0] KEEP_EVEN12   = 16'hF000;

    // Register reset values.
    localparam logic [1:0]  FAT_KIND_RST = KIND_FAT16;
    localparam logic [7:0]  SPC_RST      = 8'd1;
    localparam logic [31:0] FIRST_RST    = 32'd0;

endpackage : fcct_pkg

`default_nettype wire

[rtl/fcct_store.sv]
// Four byte-lane table store with one registered read and one write per lane.
`default_nettype none

module fcct_store
    import fcct_pkg::*;
#(
    parameter int unsigned ROWS = TABLE_BYTES_DEF / LANES
)
(
    input  wire logic                                  clk,
    input  wire logic [LANES-1:0][$clog2(ROWS)-1:0]    rd_row,
    input  wire logic [LANES-1:0]                      wr_en,
    input  wire logic [LANES-1:0][$clog2(ROWS)-1:0]    wr_row,
    input  wire logic [LANES-1:0][7:0]                 wr_data,
    output      logic [LANES-1:0][7:0]                 rd_data
);

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        logic [7:0] mem [ROWS];

        always_ff @(posedge clk)
        begin
            if (wr_en[g])
            begin
                mem[wr_row[g]] <= wr_data[g];
            end
        end

        always_ff @(posedge clk)
        begin
            rd_data[g] <= mem[rd_row[g]];
        end
    end

endmodule : fcct_store

`default_nettype wire

[rtl/fat_cluster_chain_table.sv]
// A request accepted in idle reads the store's four byte lanes; the data state then merges
// the entry, writes it back and forms the first sector; the result is registered and strobed
// by done as the block leaves that state. No new request is taken while in the data state.
// Reset: the store is cleared one row of four bytes a cycle with busy high; configuration
// writes are taken during that pass. Results cannot be stalled.
`default_nettype none

module fat_cluster_chain_table
    import fcct_pkg::*;
#(
    parameter int unsigned TABLE_BYTES = TABLE_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output      logic        busy,
    input  wire logic        req_type,
    input  wire logic [27:0] cluster,
    input  wire logic [27:0] next_value,
    output      logic        done,
    output      logic [27:0] next_cluster,
    output      logic [31:0] first_sector,
    output      logic        out_of_range,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int unsigned ROWS  = TABLE_BYTES / LANES;
    localparam int unsigned ROW_W = $clog2(ROWS);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_DATA  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [ROW_W-1:0] clr_row_reg;

    logic [1:0]  fat_kind_reg;
    logic [7:0]  spc_reg;
    logic [31:0] first_reg;

    // Request held between the read and the write-back cycle.
    logic                         wr_reg;
    logic                         odd_reg;
    logic [27:0]                  val_reg;
    logic [1:0]                   kind_reg;
    logic                         oor_reg;
    logic                         ge2_reg;
    logic [1:0]                   lo_reg;
    logic [LANES-1:0][ROW_W-1:0]  row_reg;
    logic [31:0]                  prod_reg;

    logic        done_reg;
    logic [27:0] next_cluster_reg;
    logic [31:0] first_sector_reg;
    logic        oor_out_reg;

    logic                         accept;
    logic [OFF_W-1:0]             off;
    logic [2:0]                   nbytes;
    logic                         oor_now;
    logic [LANES-1:0][ROW_W-1:0]  rd_row;
    logic [ROW_W-1:0]             base_row;
    logic [35:0]                  prod_full;

    logic [LANES-1:0][7:0]        rd_data;
    logic [LANES-1:0]             wr_en;
    logic [LANES-1:0][ROW_W-1:0]  wr_row;
    logic [LANES-1:0][7:0]        wr_data;

    logic [31:0]            word;
    logic [31:0]            new_word;
    logic [27:0]            rd_value;
    logic                   access;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // Entry offset and size under the configured kind.
    always_comb
    begin
        case (fat_kind_reg)
            KIND_FAT12:
            begin
                off    = OFF_W'(cluster) + OFF_W'(cluster[27:1]);
                nbytes = 3'd2;
            end
            KIND_FAT16:
            begin
                off    = {2'b00, cluster, 1'b0};
                nbytes = 3'd2;
            end
            KIND_FAT32:
            begin
                off    = {1'b0, cluster, 2'b00};
                nbytes = 3'd4;
            end
            default:
            begin
                off    = '0;
                nbytes = 3'd0;
            end
        endcase
    end

    assign oor_now = (nbytes != 3'd0) &&
                     ((off + OFF_W'(nbytes)) > OFF_W'(TABLE_BYTES));

    assign base_row = off[ROW_W+1:2];

    // A lane below the starting lane holds a byte of the next row.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            rd_row[l] = base_row + ROW_W'(2'(l) < off[1:0]);
        end
    end

    assign prod_full = (cluster - 28'd2) * spc_reg;

    // Gather the entry bytes in little-endian order.
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            word[8*i +: 8] = rd_data[2'(i) + lo_reg];
        end
    end

    assign access = !oor_reg && (kind_reg != KIND_NONE);

    always_comb
    begin
        new_word = word;
        rd_value = '0;
        case (kind_reg)
            KIND_FAT12:
            begin
                if (odd_reg)
                begin
                    rd_value          = 28'(word[15:4]);
                    new_word[15:0]    = (word[15:0] & KEEP_ODD12) |
                                        {val_reg[11:0], 4'h0};
                end
                else
                begin
                    rd_value          = 28'(word[15:0] & MASK_FAT12);
                    new_word[15:0]    = (word[15:0] & KEEP_EVEN12) |
                                        {4'h0, val_reg[11:0]};
                end
            end
            KIND_FAT16:
            begin
                rd_value       = 28'(word[15:0]);
                new_word[15:0] = val_reg[15:0];
            end
            KIND_FAT32:
            begin
                rd_value = 28'(word & MASK_FAT32);
                new_word = (word & KEEP_FAT32) | {4'h0, val_reg};
            end
            default:
            begin
                rd_value = '0;
            end
        endcase
    end

    // Write port: the clearing pass zeroes a whole row; otherwise each lane takes its byte.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (state_reg == ST_CLEAR)
            begin
                wr_en[l]   = 1'b1;
                wr_row[l]  = clr_row_reg;
                wr_data[l] = 8'h00;
            end
            else
            begin
                wr_en[l]   = (state_reg == ST_DATA) && (wr_reg == REQ_WRITE) && access &&
                             ((kind_reg == KIND_FAT32) || !((2'(l) - lo_reg) >= 2'd2));
                wr_row[l]  = row_reg[l];
                // The byte position within the entry wraps around the four lanes.
                wr_data[l] = new_word[8*2'(2'(l) - lo_reg) +: 8];
            end
        end
    end

    fcct_store #(
        .ROWS (ROWS)
    ) u_store (
        .clk     (clk),
        .rd_row  (rd_row),
        .wr_en   (wr_en),
        .wr_row  (wr_row),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_row_reg == ROW_W'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DATA;
                end
            end
            ST_DATA:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_row_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_DATA);
            if (state_reg == ST_CLEAR)
            begin
                clr_row_reg <= clr_row_reg + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fat_kind_reg <= FAT_KIND_RST;
            spc_reg      <= SPC_RST;
            first_reg    <= FIRST_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FAT_KIND:   fat_kind_reg <= cfg_data[1:0];
                CFG_SPC:        spc_reg      <= cfg_data[7:0];
                CFG_FIRST_DATA: first_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wr_reg   <= req_type;
            odd_reg  <= cluster[0];
            val_reg  <= next_value;
            kind_reg <= fat_kind_reg;
            oor_reg  <= oor_now;
            ge2_reg  <= (cluster >= 28'd2);
            lo_reg   <= off[1:0];
            row_reg  <= rd_row;
            prod_reg <= prod_full[31:0];
        end
        if (state_reg == ST_DATA)
        begin
            next_cluster_reg <= (access && (wr_reg == REQ_READ)) ? rd_value : 28'd0;
            first_sector_reg <= ge2_reg ? (prod_reg + first_reg) : 32'd0;
            oor_out_reg      <= oor_reg;
        end
    end

    assign done         = done_reg;
    assign next_cluster = next_cluster_reg;
    assign first_sector = first_sector_reg;
    assign out_of_range = oor_out_reg;

endmodule : fat_cluster_chain_table

`default_nettype wire

[rtl/fcct_checker.sv]
// Port-level timing checks for the FAT cluster chain table, bound to the top level.
`default_nettype none

module fcct_assertions
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done
);

    // Every accepted request is followed by its result word on done.
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted request produced no result word");

    // No result word appears without an accepted request before it.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##2 !done)
        else $error("result word without an accepted request");

    // The block is working on a request during the cycle after accepting it.
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("not busy after accepting a request");

    // A result word is shown while the block is ready for the next request.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy while a result word is shown");

endmodule : fcct_assertions

bind fat_cluster_chain_table fcct_assertions u_fcct_assertions (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

`default_nettype wire
